>>> sv/bmu_pkg.sv
// bmu_pkg: shared types and constants of the breakpoint match unit
// holds opcode and kind codes, the queued command record and the back-end status
// no dependencies
package bmu_pkg;

   // number of breakpoint slots in the table
   localparam int NUM_SLOTS   = 16;
   localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // fixed field widths
   localparam int SLOT_W      = 4;
   localparam int TARGET_W    = 16;
   localparam int ADDR_W      = 16;
   localparam int SEL_W       = 4;
   localparam int OPC_W       = 8;

   // target masks applied when a slot is set
   localparam logic [TARGET_W-1:0] SEL_MASK = 16'h000F;
   localparam logic [TARGET_W-1:0] OPC_MASK = 16'h00FF;

   // command queue between front and back
   localparam int CMD_Q_DEPTH = 2;
   localparam int QPTR_W      = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(CMD_Q_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_DISABLE = 2'd1,
      OP_CHECK   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_OFF  = 2'd0,
      KIND_ADDR = 2'd1,
      KIND_SEL  = 2'd2,
      KIND_OPC  = 2'd3
   } kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } bk_state_type;

   // classified command as it waits in the queue
   typedef struct packed {
      op_type                  op;
      logic                    slot_ok;
      logic [SLOT_IDX_W-1:0]   slot_idx;
      kind_type                kind;
      logic [TARGET_W-1:0]     target;
      logic [ADDR_W-1:0]       fetch_addr;
      logic [SEL_W-1:0]        pc_sel;
      logic [OPC_W-1:0]        opcode;
   } cmd_type;

   // back-end sequencer status
   typedef struct packed {
      logic scanning;
      logic last;
   } bk_status_type;

endpackage

>>> sv/bmu_front.sv
// bmu_front: accepts request transfers and classifies them into queue commands
// range-checks the slot number and masks the target by kind
// depends on bmu_pkg
module bmu_front (
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [bmu_pkg::SLOT_W-1:0]    req_slot,
   input  logic [1:0]                    req_kind,
   input  logic [bmu_pkg::TARGET_W-1:0]  req_target,
   input  logic [bmu_pkg::ADDR_W-1:0]    req_fetch_addr,
   input  logic [bmu_pkg::SEL_W-1:0]     req_pc_sel,
   input  logic [bmu_pkg::OPC_W-1:0]     req_opcode,
   input  logic                          q_full,
   output logic                          q_push,
   output bmu_pkg::cmd_type              q_cmd
);
   import bmu_pkg::*;

   kind_type kind;

   // hold off new transfers while the queue is full
   assign busy   = q_full;
   assign q_push = start && !q_full;
   assign kind   = kind_type'(req_kind);

   // classify the transfer
   always_comb begin
      q_cmd            = '0;
      q_cmd.op         = op_type'(req_op);
      q_cmd.slot_ok    = ({{(32-SLOT_W){1'b0}}, req_slot} < NUM_SLOTS);
      q_cmd.slot_idx   = SLOT_IDX_W'(req_slot);
      q_cmd.kind       = kind;
      q_cmd.fetch_addr = req_fetch_addr;
      q_cmd.pc_sel     = req_pc_sel;
      q_cmd.opcode     = req_opcode;
      unique case (kind)
         KIND_SEL:  q_cmd.target = req_target & SEL_MASK;
         KIND_OPC:  q_cmd.target = req_target & OPC_MASK;
         default:   q_cmd.target = req_target;
      endcase
   end

endmodule

>>> sv/bmu_cmd_fifo.sv
// bmu_cmd_fifo: short command queue between the front and the back
// register-based ring of classified commands
// depends on bmu_pkg
module bmu_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmu_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output bmu_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              empty
);
   import bmu_pkg::*;

   cmd_type             q_ff [CMD_Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(CMD_Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = q_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/bmu_back.sv
// bmu_back: slot table and command sequencer
// executes set, disable, read and suppressed checks in one step, scans the table one slot a cycle for other checks
// depends on bmu_pkg
module bmu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          suppress,
   input  bmu_pkg::cmd_type              q_cmd,
   input  logic                          q_empty,
   output logic                          q_pop,
   output bmu_pkg::bk_status_type        status,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [1:0]                    rsp_slot_kind,
   output logic [bmu_pkg::TARGET_W-1:0]  rsp_slot_target
);
   import bmu_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(NUM_SLOTS - 1);

   // slot table
   kind_type              kind_ff   [NUM_SLOTS];
   logic [TARGET_W-1:0]   target_ff [NUM_SLOTS];

   bk_state_type          state_ff, state_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  acc_ff, acc_in;
   logic [ADDR_W-1:0]     chk_addr_ff;
   logic [SEL_W-1:0]      chk_sel_ff;
   logic [OPC_W-1:0]      chk_opc_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [TARGET_W-1:0]   rsp_target_ff, rsp_target_in;

   logic [SLOT_IDX_W-1:0] rd_idx;
   kind_type              rd_kind;
   logic [TARGET_W-1:0]   rd_target;
   logic                  match;
   logic                  wr_kind_en, wr_target_en, latch_chk;
   kind_type              wr_kind;

   // single table read port, shared by scan and read-back
   assign rd_idx    = (state_ff == BK_SCAN) ? idx_ff : q_cmd.slot_idx;
   assign rd_kind   = kind_ff[rd_idx];
   assign rd_target = target_ff[rd_idx];

   // compare the scanned slot against the latched fetch
   always_comb begin
      unique case (rd_kind)
         KIND_ADDR: match = (rd_target == chk_addr_ff);
         KIND_SEL:  match = (rd_target == {{(TARGET_W-SEL_W){1'b0}}, chk_sel_ff});
         KIND_OPC:  match = (rd_target == {{(TARGET_W-OPC_W){1'b0}}, chk_opc_ff});
         default:   match = 1'b0;
      endcase
   end

   // sequencer next state and actions
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      q_pop         = 1'b0;
      wr_kind_en    = 1'b0;
      wr_target_en  = 1'b0;
      wr_kind       = q_cmd.kind;
      latch_chk     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_kind_in   = KIND_OFF;
      rsp_target_in = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_SET: begin
                     rsp_valid_in = 1'b1;
                     if (q_cmd.slot_ok) begin
                        wr_kind_en   = 1'b1;
                        wr_target_en = (q_cmd.kind != KIND_OFF);
                     end
                  end
                  OP_DISABLE: begin
                     rsp_valid_in = 1'b1;
                     wr_kind      = KIND_OFF;
                     wr_kind_en   = q_cmd.slot_ok;
                  end
                  OP_CHECK: begin
                     if (suppress) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        latch_chk = 1'b1;
                        state_in  = BK_SCAN;
                        idx_in    = '0;
                        acc_in    = 1'b0;
                     end
                  end
                  OP_READ: begin
                     rsp_valid_in = 1'b1;
                     if (q_cmd.slot_ok) begin
                        rsp_kind_in   = rd_kind;
                        rsp_target_in = rd_target;
                     end
                  end
               endcase
            end
         end
         BK_SCAN: begin
            acc_in = acc_ff | match;
            if (idx_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = acc_ff | match;
               state_in     = BK_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_IDX_W'(1);
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result and fetch capture registers
   always_ff @(posedge clock) begin
      rsp_hit_ff    <= rsp_hit_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_target_ff <= rsp_target_in;
      if (latch_chk) begin
         chk_addr_ff <= q_cmd.fetch_addr;
         chk_sel_ff  <= q_cmd.pc_sel;
         chk_opc_ff  <= q_cmd.opcode;
      end
   end

   // slot table, all slots disabled with zero target after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            kind_ff[i]   <= KIND_OFF;
            target_ff[i] <= '0;
         end
      end else begin
         if (wr_kind_en) begin
            kind_ff[q_cmd.slot_idx] <= wr_kind;
         end
         if (wr_target_en) begin
            target_ff[q_cmd.slot_idx] <= q_cmd.target;
         end
      end
   end

   assign status.scanning = (state_ff == BK_SCAN);
   assign status.last     = (idx_ff == LAST_SLOT);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot_kind   = rsp_kind_ff;
   assign rsp_slot_target = rsp_target_ff;

endmodule

>>> sv/breakpoint_match_unit.sv
// breakpoint_match_unit: debug breakpoint comparator with a 16-slot table
// set, disable, read and a suppressed check give their result through the command queue and
// the result registers; a check first scans the table, one table slot compared per cycle
// other commands are taken one per cycle while no check scans and the queue is not full
// reset: synchronous, all slots disabled with zero target, suppress cleared, queue empty
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
module breakpoint_match_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [bmu_pkg::SLOT_W-1:0]    req_slot,
   input  logic [1:0]                    req_kind,
   input  logic [bmu_pkg::TARGET_W-1:0]  req_target,
   input  logic [bmu_pkg::ADDR_W-1:0]    req_fetch_addr,
   input  logic [bmu_pkg::SEL_W-1:0]     req_pc_sel,
   input  logic [bmu_pkg::OPC_W-1:0]     req_opcode,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [1:0]                    rsp_slot_kind,
   output logic [bmu_pkg::TARGET_W-1:0]  rsp_slot_target,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);
   import bmu_pkg::*;

   cmd_type        push_cmd, head_cmd;
   logic           q_push, q_pop, q_full, q_empty;
   logic           suppress_ff;
   bk_status_type  bk_status;

   // suppress register write transfer
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         suppress_ff <= csr_data;
      end
   end

   // front end: accept and classify
   bmu_front u_front (
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_slot       (req_slot),
      .req_kind       (req_kind),
      .req_target     (req_target),
      .req_fetch_addr (req_fetch_addr),
      .req_pc_sel     (req_pc_sel),
      .req_opcode     (req_opcode),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   // command queue
   bmu_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back end: table and scan
   bmu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .suppress        (suppress_ff),
      .q_cmd           (head_cmd),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .status          (bk_status),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot_kind   (rsp_slot_kind),
      .rsp_slot_target (rsp_slot_target)
   );

   // no result while a scan is still in progress
   assert property (@(posedge clock) disable iff (reset)
      (bk_status.scanning && !bk_status.last) |=> !rsp_valid)
      else $error("result strobed in the middle of a table scan");

   // the last scan step always produces a result
   assert property (@(posedge clock) disable iff (reset)
      (bk_status.scanning && bk_status.last) |=> rsp_valid)
      else $error("table scan ended without a result");

   // a hit never carries read-back data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_slot_kind == KIND_OFF && rsp_slot_target == '0))
      else $error("hit result carries slot read-back data");

   // the back end only takes commands that are queued, and never while scanning
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty && !bk_status.scanning)
      else $error("queue pop while empty or scanning");

endmodule

>>> dv/bmu_checker.sv
`timescale 1ns / 100ps
// bmu_checker: watches the command, result and csr channels of breakpoint_match_unit
// keeps its own breakpoint table, predicts each result and compares it; uses bmu_pkg
module bmu_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [bmu_pkg::SLOT_W-1:0]    req_slot,
   input  logic [1:0]                    req_kind,
   input  logic [bmu_pkg::TARGET_W-1:0]  req_target,
   input  logic [bmu_pkg::ADDR_W-1:0]    req_fetch_addr,
   input  logic [bmu_pkg::SEL_W-1:0]     req_pc_sel,
   input  logic [bmu_pkg::OPC_W-1:0]     req_opcode,
   input  logic                          rsp_valid,
   input  logic                          rsp_hit,
   input  logic [1:0]                    rsp_slot_kind,
   input  logic [bmu_pkg::TARGET_W-1:0]  rsp_slot_target,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_data,
   output int                            fail_count,
   output int                            answers_pending
);
   import bmu_pkg::*;

   typedef struct packed {
      logic                hit;
      logic [1:0]          kind;
      logic [TARGET_W-1:0] target;
   } bp_answer_type;

   // shadow breakpoint table and suppress flag
   kind_type            bp_kind   [NUM_SLOTS];
   logic [TARGET_W-1:0] bp_target [NUM_SLOTS];
   logic                suppress_on;

   bp_answer_type answer_q [$];
   int            errors;

   // applies one command to the shadow table and returns the result it should give
   function automatic bp_answer_type predict_answer(input op_type op,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input kind_type kind,
                                                    input logic [TARGET_W-1:0] tgt,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [SEL_W-1:0] sel,
                                                    input logic [OPC_W-1:0] opc);
      bp_answer_type ans;
      logic          in_range;
      ans      = '0;
      in_range = int'(slot) < NUM_SLOTS;
      case (op)
         OP_SET: begin
            if (in_range) begin
               if (kind == KIND_OFF) begin
                  // target is kept, only the kind drops to off
                  bp_kind[slot] = KIND_OFF;
               end else begin
                  bp_kind[slot] = kind;
                  case (kind)
                     KIND_SEL: bp_target[slot] = tgt & SEL_MASK;
                     KIND_OPC: bp_target[slot] = tgt & OPC_MASK;
                     default:  bp_target[slot] = tgt;
                  endcase
               end
            end
         end
         OP_DISABLE: begin
            if (in_range) bp_kind[slot] = KIND_OFF;
         end
         OP_CHECK: begin
            if (!suppress_on) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  case (bp_kind[i])
                     KIND_ADDR: if (bp_target[i] == addr) ans.hit = 1'b1;
                     KIND_SEL:  if (bp_target[i] == TARGET_W'(sel)) ans.hit = 1'b1;
                     KIND_OPC:  if (bp_target[i] == TARGET_W'(opc)) ans.hit = 1'b1;
                     default: ;
                  endcase
               end
            end
         end
         default: begin
            if (in_range) begin
               ans.kind   = bp_kind[slot];
               ans.target = bp_target[slot];
            end
         end
      endcase
      return ans;
   endfunction

   // monitor: compare results, then record new command and csr transfers
   always @(posedge clock) begin
      bp_answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            bp_kind[i]   = KIND_OFF;
            bp_target[i] = '0;
         end
         suppress_on = 1'b0;
         answer_q.delete();
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, hit %0d kind %0d target %h", $time,
                        rsp_hit, rsp_slot_kind, rsp_slot_target);
            end else begin
               want = answer_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  errors++;
                  $display("%0t: hit mismatch, expected %0d actual %0d", $time,
                           want.hit, rsp_hit);
               end
               if (rsp_slot_kind !== want.kind) begin
                  errors++;
                  $display("%0t: slot_kind mismatch, expected %0d actual %0d", $time,
                           want.kind, rsp_slot_kind);
               end
               if (rsp_slot_target !== want.target) begin
                  errors++;
                  $display("%0t: slot_target mismatch, expected %h actual %h", $time,
                           want.target, rsp_slot_target);
               end
            end
         end
         if (start && !busy) begin
            answer_q.push_back(predict_answer(op_type'(req_op), req_slot,
                                              kind_type'(req_kind), req_target,
                                              req_fetch_addr, req_pc_sel, req_opcode));
         end
         if (csr_valid && csr_ready) suppress_on = csr_data;
      end
      fail_count      <= errors;
      answers_pending <= answer_q.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for breakpoint_match_unit
// drives directed then random commands and suppress writes; depends on bmu_pkg, bmu_checker and breakpoint_match_unit
module tb_top;
   import bmu_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = NUM_SLOTS + 8;
   localparam int PHASE_COUNT  = 4;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_op;
   logic [SLOT_W-1:0]   req_slot;
   logic [1:0]          req_kind;
   logic [TARGET_W-1:0] req_target;
   logic [ADDR_W-1:0]   req_fetch_addr;
   logic [SEL_W-1:0]    req_pc_sel;
   logic [OPC_W-1:0]    req_opcode;
   logic                rsp_valid;
   logic                rsp_hit;
   logic [1:0]          rsp_slot_kind;
   logic [TARGET_W-1:0] rsp_slot_target;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_data;

   int fail_count;
   int answers_pending;
   int cycle_count;
   int cmds_sent;
   int hits_seen;
   int csr_writes;
   int calm_left;
   bit idling_on;

   // last targets set per slot, used to steer checks toward hits
   logic [TARGET_W-1:0] armed_target [NUM_SLOTS];

   int   phase_items    [PHASE_COUNT] = '{600, 200, 600, 600};
   logic phase_suppress [PHASE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b0};

   breakpoint_match_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_kind        (req_kind),
      .req_target      (req_target),
      .req_fetch_addr  (req_fetch_addr),
      .req_pc_sel      (req_pc_sel),
      .req_opcode      (req_opcode),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot_kind   (rsp_slot_kind),
      .rsp_slot_target (rsp_slot_target),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   bmu_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_kind        (req_kind),
      .req_target      (req_target),
      .req_fetch_addr  (req_fetch_addr),
      .req_pc_sel      (req_pc_sel),
      .req_opcode      (req_opcode),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot_kind   (rsp_slot_kind),
      .rsp_slot_target (rsp_slot_target),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
   end

   // count hits for the summary
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_hit) hits_seen++;
   end

   // one command transfer; start stays high afterwards
   task automatic send_cmd(input op_type op, input logic [SLOT_W-1:0] slot,
                           input logic [1:0] kind, input logic [TARGET_W-1:0] tgt,
                           input logic [ADDR_W-1:0] addr, input logic [SEL_W-1:0] sel,
                           input logic [OPC_W-1:0] opc);
      start          <= 1'b1;
      req_op         <= op;
      req_slot       <= slot;
      req_kind       <= kind;
      req_target     <= tgt;
      req_fetch_addr <= addr;
      req_pc_sel     <= sel;
      req_opcode     <= opc;
      do @(posedge clock); while (busy);
      cmds_sent++;
   endtask

   // random sender gaps, with calm stretches of back-to-back commands
   task automatic maybe_pause();
      if (!idling_on) return;
      if (calm_left > 0) begin
         calm_left--;
      end else if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(20, 60);
      end else if ($urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // let every outstanding result come back, then let the scan settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // suppress register write, only with the block idle
   task automatic write_suppress(input logic value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // mostly sets and checks, checks often aimed at armed targets
   task automatic random_cmd();
      int                  pick;
      int                  slot;
      int                  aim;
      logic [1:0]          kind;
      logic [TARGET_W-1:0] tgt;
      logic [ADDR_W-1:0]   addr;
      logic [SEL_W-1:0]    sel;
      logic [OPC_W-1:0]    opc;
      op_type              op;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, NUM_SLOTS - 1);
      kind = ($urandom_range(0, 19) == 0) ? 2'(KIND_OFF) : 2'($urandom_range(1, 3));
      tgt  = TARGET_W'($urandom);
      addr = ADDR_W'($urandom);
      sel  = SEL_W'($urandom);
      opc  = OPC_W'($urandom);
      case ($urandom_range(0, 7))
         0: tgt = '0;
         1: tgt = '1;
         default: ;
      endcase
      if (pick < 30)      op = OP_SET;
      else if (pick < 40) op = OP_DISABLE;
      else if (pick < 85) op = OP_CHECK;
      else                op = OP_READ;
      if (op == OP_SET && kind != KIND_OFF) armed_target[slot] = tgt;
      if (op == OP_CHECK) begin
         aim = $urandom_range(0, NUM_SLOTS - 1);
         if ($urandom_range(0, 1) == 0) addr = armed_target[aim];
         if ($urandom_range(0, 2) == 0) sel  = armed_target[aim][SEL_W-1:0];
         if ($urandom_range(0, 2) == 0) opc  = armed_target[aim][OPC_W-1:0];
      end
      send_cmd(op, SLOT_W'(slot), kind, tgt, addr, sel, opc);
   endtask

   // main sequence
   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_op         <= OP_SET;
      req_slot       <= '0;
      req_kind       <= KIND_OFF;
      req_target     <= '0;
      req_fetch_addr <= '0;
      req_pc_sel     <= '0;
      req_opcode     <= '0;
      csr_valid      <= 1'b0;
      csr_data       <= 1'b0;
      cmds_sent  = 0;
      csr_writes = 0;
      calm_left  = 0;
      idling_on  = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) armed_target[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_suppress(1'b0);

      // directed: empty table, disabled zero targets must not match
      send_cmd(OP_READ,  4'd0,  '0, '0, '0, '0, '0);
      send_cmd(OP_READ,  4'd15, '0, '0, '0, '0, '0);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, '0, '0, '0);
      // directed: one slot of each kind, masking of wide targets
      send_cmd(OP_SET,   4'd0,  KIND_ADDR, 16'hFFFF, '0, '0, '0);
      send_cmd(OP_SET,   4'd15, KIND_SEL,  16'hFFFF, '0, '0, '0);
      send_cmd(OP_SET,   4'd7,  KIND_OPC,  16'hABCD, '0, '0, '0);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'hFFFF, 4'd0,  8'h00);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h0000, 4'hF,  8'h00);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h0000, 4'd0,  8'hCD);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h1234, 4'd3,  8'hAB);
      send_cmd(OP_READ,  4'd0,  '0, '0, '0, '0, '0);
      send_cmd(OP_READ,  4'd15, '0, '0, '0, '0, '0);
      send_cmd(OP_READ,  4'd7,  '0, '0, '0, '0, '0);
      // directed: set with kind off keeps the target, disable, no match, then a hit on a zero address slot
      send_cmd(OP_SET,   4'd0,  KIND_OFF, 16'h5555, '0, '0, '0);
      send_cmd(OP_READ,  4'd0,  '0, '0, '0, '0, '0);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'hFFFF, 4'd0, 8'h00);
      send_cmd(OP_DISABLE, 4'd15, '0, '0, '0, '0, '0);
      send_cmd(OP_READ,  4'd15, '0, '0, '0, '0, '0);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h0000, 4'hF, 8'h00);
      send_cmd(OP_SET,   4'd3,  KIND_ADDR, 16'h0000, '0, '0, '0);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h0000, 4'd0, 8'h00);
      // directed: suppressed check against a live opcode slot
      write_suppress(1'b1);
      send_cmd(OP_CHECK, 4'd0,  '0, '0, 16'h0000, 4'd0, 8'hCD);
      send_cmd(OP_READ,  4'd7,  '0, '0, '0, '0, '0);

      // random phases, no sender gaps in the last one
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_suppress(phase_suppress[p]);
         idling_on = (p != PHASE_COUNT - 1);
         for (int n = 0; n < phase_items[p]; n++) begin
            maybe_pause();
            random_cmd();
         end
      end

      drain();
      $display("run covered %0d commands, %0d suppress writes, %0d breakpoint hits",
               cmds_sent, csr_writes, hits_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
